[sv/bba_pkg.sv]
// Package for the buddy block allocator: request codes, sequencer states and
// the default sizes handed to the top level. Depends on nothing.

package bba_pkg;

	localparam int DEF_POOL_UNITS = 131072;
	localparam int DEF_MAX_ORDER  = 22;
	localparam int MIN_ORDER      = 5;
	localparam int HDR_BYTES      = 16;
	localparam int MIN_BYTES      = 32;
	localparam int ORD_W          = 5;
	localparam int CFG_W          = 23;
	localparam logic [CFG_W-1:0] DEF_POOL_BYTES = 23'd4194304;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_INIT  = 2'd2
	} req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR,
		ST_I_LOOP,
		ST_I_ADV,
		ST_A_SIZE,
		ST_A_FIND,
		ST_A_SPLIT,
		ST_A_SP1,
		ST_A_SP2,
		ST_A_SP3,
		ST_A_FIN,
		ST_A_FIN2,
		ST_F_RD,
		ST_F_CHK,
		ST_M_TEST,
		ST_M_RD,
		ST_M_CHK,
		ST_M_R2,
		ST_M_PUSH,
		ST_P_W,
		ST_P_RD,
		ST_P_WB,
		ST_R_RD,
		ST_R_GET,
		ST_R_PRD,
		ST_R_PWB,
		ST_R_N,
		ST_R_NWB,
		ST_FIN
	} st_t;

endpackage

[sv/bba_ram.sv]
// Generic single-port RAM with a registered read port.
// Depends on nothing.

module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[sv/buddy_block_allocator_core.sv]
// Buddy block allocator core. Uses bba_pkg and one bba_ram for per-unit state.
// After reset a clearing pass over all POOL_UNITS units runs with busy high.
// Initialise clears every unit, then pushes each initial block and steps down one order
// whenever the remainder is smaller. Allocate sizes the request, searches the free lists
// and splits; free merges buddies step by step. Every step waits on the single RAM port.
// One request at a time; the result strobe lasts one cycle and cannot stall.

module buddy_block_allocator_core #(
	parameter int POOL_UNITS = bba_pkg::DEF_POOL_UNITS,
	parameter int MAX_ORDER  = bba_pkg::DEF_MAX_ORDER
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [30:0] req_size,
	input  logic [22:0] free_addr,
	// result channel
	output logic        done,
	output logic        status,
	output logic [22:0] block_addr,
	output logic [17:0] live_count,
	// pool size register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [22:0] cfg_data
);

	localparam int AW  = $clog2(POOL_UNITS);
	localparam int UW  = AW + 1;
	localparam int OW  = bba_pkg::ORD_W;
	// unit word: {next, prev, order, free, allocated start}
	localparam int AM_B   = 0;
	localparam int FR_B   = 1;
	localparam int ORD_LO = 2;
	localparam int PRV_LO = ORD_LO + OW;
	localparam int NXT_LO = PRV_LO + UW;
	localparam int WW     = NXT_LO + UW;
	localparam logic [UW-1:0] NIL      = UW'(POOL_UNITS);
	localparam logic [AW-1:0] LAST     = AW'(POOL_UNITS - 1);
	localparam logic [OW-1:0] ORD_MAX  = OW'(MAX_ORDER);
	localparam logic [OW-1:0] ORD_MIN  = OW'(bba_pkg::MIN_ORDER);
	localparam logic [31:0]   POOL_LIM = 32'(POOL_UNITS) << bba_pkg::MIN_ORDER;

	// control state
	bba_pkg::st_t state_q, state_d, ret_q, ret_d;
	logic [AW-1:0] clr_q;
	logic          clr_init_q;
	logic [UW-1:0] head_q [0:MAX_ORDER];
	logic [UW-1:0] live_q;
	logic [UW-1:0] pool_used_q;
	logic [22:0]   pool_bytes_q;
	logic          done_q;

	// working registers
	logic [OW-1:0] e_q, i_q, pe_q, ie_q;
	logic [31:0]   s_q, rem_q;
	logic [UW-1:0] u_q, v_q, b_q, pu_q, ph_q, ru_q, rn_q, rp_q, start_q;
	logic          rs_q;
	logic [22:0]   ra_q;

	// RAM port
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [WW-1:0] ram_wdata, ram_rdata;

	// head table port
	logic [OW-1:0] hidx;
	logic [UW-1:0] hval;
	logic          hw_en;
	logic [OW-1:0] hw_idx;
	logic [UW-1:0] hw_val;

	logic          acc;
	logic [31:0]   s_w;
	logic          a_bad;
	logic [22:0]   offs;
	logic [17:0]   f_unit;
	logic          f_ok;
	logic [31:0]   rem_init;
	logic          rd_am, rd_fr;
	logic [OW-1:0] rd_ord;
	logic [UW-1:0] rd_prv, rd_nxt;
	logic [OW-1:0] m_sh;
	logic [UW:0]   m_sz, m_b;
	logic [UW-1:0] m_bits;
	logic          m_stop;
	logic [31:0]   i_sz_b;
	logic [UW-1:0] i_sz_u, sp_half, lo;

	bba_ram #(
		.WIDTH(WW),
		.DEPTH(POOL_UNITS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign acc       = start && (state_q == bba_pkg::ST_IDLE);
	assign busy      = (state_q != bba_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign status    = rs_q;
	assign block_addr = ra_q;
	assign live_count = 18'(live_q);

	// request decode: size with header, free address checks, clamped pool size
	assign s_w      = 32'(req_size) + 32'(bba_pkg::HDR_BYTES);
	assign a_bad    = (req_size == 31'd0) || (s_w > (32'd1 << MAX_ORDER));
	assign offs     = free_addr - 23'd8;
	assign f_unit   = offs[22:5];
	assign f_ok     = (free_addr >= 23'd8) && (offs[4:0] == 5'd0)
		&& (32'(f_unit) <= 32'(pool_used_q)) && (32'(f_unit) < 32'(POOL_UNITS));
	assign rem_init = (32'(pool_bytes_q) > POOL_LIM) ? POOL_LIM : 32'(pool_bytes_q);

	// fields of the word read last cycle
	assign rd_am  = ram_rdata[AM_B];
	assign rd_fr  = ram_rdata[FR_B];
	assign rd_ord = ram_rdata[ORD_LO +: OW];
	assign rd_prv = ram_rdata[PRV_LO +: UW];
	assign rd_nxt = ram_rdata[NXT_LO +: UW];

	// buddy of the block at u_q, order e_q
	assign m_sh   = e_q - ORD_MIN;
	assign m_sz   = (UW+1)'(1) << m_sh;
	assign m_bits = u_q >> m_sh;
	assign m_b    = m_bits[0] ? ({1'b0, u_q} - m_sz) : ({1'b0, u_q} + m_sz);
	assign m_stop = (e_q >= ORD_MAX) || (!m_bits[0] && (m_b >= {1'b0, pool_used_q}));

	assign i_sz_b  = 32'd1 << ie_q;
	assign i_sz_u  = UW'(1) << (ie_q - ORD_MIN);
	assign sp_half = UW'(1) << (i_q - ORD_MIN - OW'(1));
	assign lo      = (b_q < u_q) ? b_q : u_q;

	assign hidx = (state_q == bba_pkg::ST_P_W) ? pe_q : i_q;
	assign hval = head_q[hidx];

	// next state, with a one-level return for the push and unlink routines
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			bba_pkg::ST_IDLE: begin
				if (acc) begin
					case (bba_pkg::req_t'(req_type))
						bba_pkg::REQ_INIT:  state_d = bba_pkg::ST_CLR;
						bba_pkg::REQ_ALLOC: state_d = a_bad ? bba_pkg::ST_FIN : bba_pkg::ST_A_SIZE;
						bba_pkg::REQ_FREE:  state_d = f_ok ? bba_pkg::ST_F_RD : bba_pkg::ST_FIN;
						default:            state_d = bba_pkg::ST_FIN;
					endcase
				end
			end
			bba_pkg::ST_CLR: begin
				if (clr_q == LAST) begin
					state_d = clr_init_q ? bba_pkg::ST_I_LOOP : bba_pkg::ST_IDLE;
				end
			end
			bba_pkg::ST_I_LOOP: begin
				if (rem_q <= 32'(bba_pkg::MIN_BYTES)) begin
					state_d = bba_pkg::ST_FIN;
				end else if (rem_q >= i_sz_b) begin
					state_d = bba_pkg::ST_P_W;
					ret_d   = bba_pkg::ST_I_ADV;
				end
			end
			bba_pkg::ST_I_ADV:  state_d = bba_pkg::ST_I_LOOP;
			bba_pkg::ST_A_SIZE: begin
				if ((32'd1 << e_q) >= s_q) begin
					state_d = bba_pkg::ST_A_FIND;
				end
			end
			bba_pkg::ST_A_FIND: begin
				if (hval != NIL) begin
					state_d = bba_pkg::ST_A_SPLIT;
				end else if (i_q == ORD_MAX) begin
					state_d = bba_pkg::ST_FIN;
				end
			end
			bba_pkg::ST_A_SPLIT: begin
				state_d = bba_pkg::ST_R_RD;
				ret_d   = (i_q == e_q) ? bba_pkg::ST_A_FIN : bba_pkg::ST_A_SP1;
			end
			bba_pkg::ST_A_SP1: begin
				state_d = bba_pkg::ST_P_W;
				ret_d   = bba_pkg::ST_A_SP2;
			end
			bba_pkg::ST_A_SP2: begin
				state_d = bba_pkg::ST_P_W;
				ret_d   = bba_pkg::ST_A_SP3;
			end
			bba_pkg::ST_A_SP3:  state_d = bba_pkg::ST_A_SPLIT;
			bba_pkg::ST_A_FIN:  state_d = bba_pkg::ST_A_FIN2;
			bba_pkg::ST_A_FIN2: state_d = bba_pkg::ST_FIN;
			bba_pkg::ST_F_RD:   state_d = bba_pkg::ST_F_CHK;
			bba_pkg::ST_F_CHK: begin
				if (rd_am) begin
					state_d = bba_pkg::ST_P_W;
					ret_d   = bba_pkg::ST_M_TEST;
				end else begin
					state_d = bba_pkg::ST_FIN;
				end
			end
			bba_pkg::ST_M_TEST: state_d = m_stop ? bba_pkg::ST_FIN : bba_pkg::ST_M_RD;
			bba_pkg::ST_M_RD:   state_d = bba_pkg::ST_M_CHK;
			bba_pkg::ST_M_CHK: begin
				if (rd_fr && (rd_ord == e_q)) begin
					state_d = bba_pkg::ST_R_RD;
					ret_d   = bba_pkg::ST_M_R2;
				end else begin
					state_d = bba_pkg::ST_FIN;
				end
			end
			bba_pkg::ST_M_R2: begin
				state_d = bba_pkg::ST_R_RD;
				ret_d   = bba_pkg::ST_M_PUSH;
			end
			bba_pkg::ST_M_PUSH: begin
				state_d = bba_pkg::ST_P_W;
				ret_d   = bba_pkg::ST_M_TEST;
			end
			bba_pkg::ST_P_W:   state_d = (hval != NIL) ? bba_pkg::ST_P_RD : ret_q;
			bba_pkg::ST_P_RD:  state_d = bba_pkg::ST_P_WB;
			bba_pkg::ST_P_WB:  state_d = ret_q;
			bba_pkg::ST_R_RD:  state_d = bba_pkg::ST_R_GET;
			bba_pkg::ST_R_GET: state_d = (rd_prv != NIL) ? bba_pkg::ST_R_PRD : bba_pkg::ST_R_N;
			bba_pkg::ST_R_PRD: state_d = bba_pkg::ST_R_PWB;
			bba_pkg::ST_R_PWB: state_d = bba_pkg::ST_R_N;
			bba_pkg::ST_R_N:   state_d = (rn_q != NIL) ? bba_pkg::ST_R_NWB : ret_q;
			bba_pkg::ST_R_NWB: state_d = ret_q;
			bba_pkg::ST_FIN:   state_d = bba_pkg::ST_IDLE;
			default:           state_d = bba_pkg::ST_IDLE;
		endcase
	end

	// RAM and head table accesses for each step
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = AW'(ru_q);
		ram_wdata = ram_rdata;
		hw_en     = 1'b0;
		hw_idx    = pe_q;
		hw_val    = pu_q;
		case (state_q)
			bba_pkg::ST_CLR: begin
				// drop every free and allocated mark
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			bba_pkg::ST_A_FIN: ram_addr = AW'(u_q);
			bba_pkg::ST_A_FIN2: begin
				ram_we                    = 1'b1;
				ram_addr                  = AW'(u_q);
				ram_wdata[AM_B]           = 1'b1;
				ram_wdata[ORD_LO +: OW]   = e_q;
			end
			bba_pkg::ST_F_RD: ram_addr = AW'(u_q);
			bba_pkg::ST_M_RD: ram_addr = AW'(b_q);
			bba_pkg::ST_P_W: begin
				// new head: links to the old head, no predecessor
				ram_we    = 1'b1;
				ram_addr  = AW'(pu_q);
				ram_wdata = {hval, NIL, pe_q, 1'b1, 1'b0};
				hw_en     = 1'b1;
			end
			bba_pkg::ST_P_RD: ram_addr = AW'(ph_q);
			bba_pkg::ST_P_WB: begin
				ram_we                  = 1'b1;
				ram_addr                = AW'(ph_q);
				ram_wdata[PRV_LO +: UW] = pu_q;
			end
			bba_pkg::ST_R_RD: ram_addr = AW'(ru_q);
			bba_pkg::ST_R_GET: begin
				ram_we          = 1'b1;
				ram_addr        = AW'(ru_q);
				ram_wdata[FR_B] = 1'b0;
				if ((rd_prv == NIL) && (rd_ord <= ORD_MAX)) begin
					hw_en  = 1'b1;
					hw_idx = rd_ord;
					hw_val = rd_nxt;
				end
			end
			bba_pkg::ST_R_PRD: ram_addr = AW'(rp_q);
			bba_pkg::ST_R_PWB: begin
				ram_we                  = 1'b1;
				ram_addr                = AW'(rp_q);
				ram_wdata[NXT_LO +: UW] = rn_q;
			end
			bba_pkg::ST_R_N: ram_addr = AW'(rn_q);
			bba_pkg::ST_R_NWB: begin
				ram_we                  = 1'b1;
				ram_addr                = AW'(rn_q);
				ram_wdata[PRV_LO +: UW] = rp_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// control registers; reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bba_pkg::ST_CLR;
			ret_q        <= bba_pkg::ST_IDLE;
			clr_q        <= '0;
			clr_init_q   <= 1'b0;
			live_q       <= '0;
			pool_used_q  <= '0;
			pool_bytes_q <= bba_pkg::DEF_POOL_BYTES;
			done_q       <= 1'b0;
			for (int k = 0; k <= MAX_ORDER; k++) begin
				head_q[k] <= NIL;
			end
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			done_q  <= (state_q == bba_pkg::ST_FIN);
			if (cfg_valid) begin
				pool_bytes_q <= cfg_data;
			end
			if (hw_en && (hw_idx <= ORD_MAX)) begin
				head_q[hw_idx] <= hw_val;
			end
			case (state_q)
				bba_pkg::ST_IDLE: begin
					if (acc && (bba_pkg::req_t'(req_type) == bba_pkg::REQ_INIT)) begin
						clr_q       <= '0;
						clr_init_q  <= 1'b1;
						live_q      <= '0;
						pool_used_q <= '0;
						for (int k = 0; k <= MAX_ORDER; k++) begin
							head_q[k] <= NIL;
						end
					end
				end
				bba_pkg::ST_CLR: clr_q <= clr_q + AW'(1);
				bba_pkg::ST_I_LOOP: begin
					if (rem_q <= 32'(bba_pkg::MIN_BYTES)) begin
						pool_used_q <= start_q;
					end
				end
				bba_pkg::ST_A_FIN2: live_q <= live_q + UW'(1);
				bba_pkg::ST_F_CHK: begin
					if (rd_am) begin
						live_q <= live_q - UW'(1);
					end
				end
				default: begin
					clr_q <= clr_q;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			bba_pkg::ST_IDLE: begin
				if (acc) begin
					// hold failure until a step proves success
					rs_q    <= 1'b1;
					ra_q    <= '0;
					s_q     <= s_w;
					e_q     <= ORD_MIN;
					u_q     <= UW'(f_unit);
					rem_q   <= rem_init;
					start_q <= '0;
					ie_q    <= ORD_MAX;
				end
			end
			bba_pkg::ST_I_LOOP: begin
				if (rem_q <= 32'(bba_pkg::MIN_BYTES)) begin
					rs_q <= 1'b0;
				end else if (rem_q < i_sz_b) begin
					ie_q <= ie_q - OW'(1);
				end else begin
					pu_q <= start_q;
					pe_q <= ie_q;
				end
			end
			bba_pkg::ST_I_ADV: begin
				rem_q   <= rem_q - i_sz_b;
				start_q <= start_q + i_sz_u;
			end
			bba_pkg::ST_A_SIZE: begin
				if ((32'd1 << e_q) >= s_q) begin
					i_q <= e_q;
				end else begin
					e_q <= e_q + OW'(1);
				end
			end
			bba_pkg::ST_A_FIND: begin
				if (hval == NIL) begin
					i_q <= i_q + OW'(1);
				end
			end
			bba_pkg::ST_A_SPLIT: begin
				ru_q <= hval;
				v_q  <= hval;
				u_q  <= hval;
			end
			bba_pkg::ST_A_SP1: begin
				pu_q <= v_q;
				pe_q <= i_q - OW'(1);
			end
			bba_pkg::ST_A_SP2: begin
				// upper half goes on last, so it is handed out first
				pu_q <= v_q + sp_half;
				pe_q <= i_q - OW'(1);
			end
			bba_pkg::ST_A_SP3: i_q <= i_q - OW'(1);
			bba_pkg::ST_A_FIN2: begin
				rs_q <= 1'b0;
				ra_q <= 23'({u_q, 5'b01000});
			end
			bba_pkg::ST_F_CHK: begin
				if (rd_am) begin
					rs_q <= 1'b0;
					e_q  <= rd_ord;
					pu_q <= u_q;
					pe_q <= rd_ord;
				end
			end
			bba_pkg::ST_M_TEST: b_q  <= UW'(m_b);
			bba_pkg::ST_M_CHK:  ru_q <= u_q;
			bba_pkg::ST_M_R2:   ru_q <= b_q;
			bba_pkg::ST_M_PUSH: begin
				u_q  <= lo;
				e_q  <= e_q + OW'(1);
				pu_q <= lo;
				pe_q <= e_q + OW'(1);
			end
			bba_pkg::ST_P_W: ph_q <= hval;
			bba_pkg::ST_R_GET: begin
				rn_q <= rd_nxt;
				rp_q <= rd_prv;
			end
			default: begin
				rs_q <= rs_q;
			end
		endcase
	end

endmodule
